// ===== hw/rtl/erswma_pkg.sv =====
`timescale 1ns / 1ps

package erswma_pkg;

    // field widths
    localparam int ECHO_W   = 16;
    localparam int HALF_W   = 8;
    localparam int SPS_W    = 7;
    localparam int RANGE_W  = 24;
    localparam int SPEED_W  = 32;
    localparam int MEM_W    = RANGE_W + SPEED_W;

    // stream payload widths, padded to whole bytes
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 56;

    // configuration port
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 8;

    localparam logic [CFG_IDX_W-1:0] REG_HALF_SOUND  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 1'd1;

    localparam logic [HALF_W-1:0] HALF_SOUND_RST  = 8'd170;
    localparam logic [SPS_W-1:0]  SAMPLE_RATE_RST = 7'd20;

    // default filter length
    localparam int WINDOW_DEF = 5;

    // defaults for the serial divider
    localparam int DIV_NUM_W_DEF = 37;
    localparam int DIV_DEN_DEF   = 15;

endpackage

// ===== hw/rtl/erswma_serial_div.sv =====
`timescale 1ns / 1ps

// divides by a constant through its rounded-up reciprocal, exact for every numerator
// of NUM_W bits; the product is built 16 reciprocal bits per cycle, top digit first
module erswma_serial_div #(
    parameter int NUM_W   = erswma_pkg::DIV_NUM_W_DEF,
    parameter int DIVISOR = erswma_pkg::DIV_DEN_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    output logic             busy,
    output logic [NUM_W-1:0] quot
);

    localparam int SHIFT   = NUM_W + $clog2(DIVISOR);
    localparam int RECIP_W = NUM_W + 1;
    localparam int STEPS   = (RECIP_W + 15) / 16;
    localparam int PAD_W   = STEPS * 16;
    localparam int ACC_W   = NUM_W + PAD_W;
    localparam int CNT_W   = $clog2(STEPS + 1);
    localparam logic [PAD_W-1:0] RECIP =
        PAD_W'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    logic [NUM_W-1:0]  numer_reg;
    logic [PAD_W-1:0]  recip_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;

    logic [NUM_W+15:0] part;

    assign part = numer_reg * recip_reg[PAD_W-1 -: 16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(STEPS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // product accumulates one digit per cycle, earlier digits move up 16 bits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            numer_reg <= numer;
            recip_reg <= RECIP;
            acc_reg   <= '0;
        end
        else if (busy_reg)
        begin
            recip_reg <= recip_reg << 16;
            acc_reg   <= (acc_reg << 16) + ACC_W'(part);
        end
    end

    assign busy = busy_reg;
    assign quot = NUM_W'(acc_reg >> SHIFT);

endmodule

// ===== hw/rtl/echo_range_speed_wma_filter_unit.sv =====
`timescale 1ns / 1ps

// ultrasonic echo ranging filter. each input transaction carries one echo round-trip
// time in microseconds; it is scaled by half the speed of sound (register 0) into a
// raw distance in micrometres, and the raw speed is the distance minus the previous
// filtered distance times the sample rate (register 1). both raw values go into a ring
// of the last WINDOW entries held in one synchronous memory (zero after reset through
// per-entry valid bits, no clearing pass). each output transaction carries linearly
// weighted moving averages of both rings (newest weight WINDOW, oldest 1), divided by
// WINDOW*(WINDOW+1)/2 and rounded to nearest, ties away from zero. one item is in work
// at a time. the work is the memory walk (one entry per cycle) and the reciprocal
// multiply that forms both averages, 16 reciprocal bits per cycle. a finished result
// waits in the output register while the next item is accepted. the user must write
// configuration only while the block is idle; the block itself does not enforce it.
module echo_range_speed_wma_filter_unit #(
    parameter int WINDOW = erswma_pkg::WINDOW_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input stream: [15:0] echo_time_us
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [erswma_pkg::S_DATA_W-1:0]     s_tdata,
    // output stream: [23:0] filtered_range_um, [55:24] filtered_speed_um_s
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [erswma_pkg::M_DATA_W-1:0]     m_tdata,
    // configuration writes
    input  logic                                cfg_we,
    input  logic [erswma_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [erswma_pkg::CFG_W-1:0]        cfg_data
);

    localparam int RANGE_W  = erswma_pkg::RANGE_W;
    localparam int SPEED_W  = erswma_pkg::SPEED_W;
    localparam int MEM_W    = erswma_pkg::MEM_W;
    localparam int HALF_W   = erswma_pkg::HALF_W;
    localparam int SPS_W    = erswma_pkg::SPS_W;
    localparam int ECHO_W   = erswma_pkg::ECHO_W;

    // filter geometry
    localparam int DEN      = WINDOW * (WINDOW + 1) / 2;
    localparam int DEN_BITS = $clog2(DEN + 1);
    localparam int SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int WGT_W    = $clog2(WINDOW + 1);
    localparam int RSUM_W   = RANGE_W + DEN_BITS;
    localparam int SSUM_W   = SPEED_W + 1 + DEN_BITS;
    localparam int RPROD_W  = RANGE_W + WGT_W;
    localparam int SPROD_W  = SPEED_W + WGT_W + 1;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);
    localparam logic [WGT_W-1:0]  TOP_WGT   = WGT_W'(WINDOW);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SPEED = 3'd1;
    localparam logic [2:0] ST_WRITE = 3'd2;
    localparam logic [2:0] ST_WALK  = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_ROUND = 3'd5;
    localparam logic [2:0] ST_DIV   = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    // configuration registers
    logic [HALF_W-1:0] half_sound_reg;
    logic [SPS_W-1:0]  sample_rate_reg;

    // control state
    logic [2:0]        state_reg, state_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SLOT_W-1:0] rd_idx_reg, rd_idx_next;
    logic [WGT_W-1:0]  wgt_reg, wgt_next;
    logic              rd_vld_reg;
    logic              m_tvalid_reg;
    logic [WINDOW-1:0] valid_reg;

    // datapath
    logic [RANGE_W-1:0]        raw_range_reg;
    logic signed [SPEED_W-1:0] raw_speed_reg;
    logic [RANGE_W-1:0]        last_filt_reg;
    logic [WGT_W-1:0]          wgt_pipe_reg;
    logic [MEM_W-1:0]          rd_data_reg;
    logic                      rd_hit_reg;
    logic [RSUM_W-1:0]         acc_r_reg;
    logic signed [SSUM_W-1:0]  acc_s_reg;
    logic                      neg_reg;
    logic [RANGE_W-1:0]        out_range_reg;
    logic [SPEED_W-1:0]        out_speed_reg;

    // ring memory: {speed, range} per slot
    logic [MEM_W-1:0] ring_mem [WINDOW];

    logic [ECHO_W-1:0]         echo;
    logic                      in_fire;
    logic                      out_free;
    logic                      mem_we;
    logic signed [RANGE_W:0]   diff;
    logic signed [RANGE_W+SPS_W+1:0] speed_prod;
    logic [RANGE_W-1:0]        rd_range;
    logic signed [SPEED_W-1:0] rd_speed;
    logic [RPROD_W-1:0]        rprod;
    logic signed [SPROD_W-1:0] sprod;
    logic [SSUM_W-1:0]         s_mag;
    logic [RSUM_W-1:0]         rdiv_numer;
    logic [SSUM_W-1:0]         sdiv_numer;
    logic [RSUM_W-1:0]         rdiv_quot;
    logic [SSUM_W-1:0]         sdiv_quot;
    logic                      rdiv_busy;
    logic                      sdiv_busy;
    logic                      div_start;
    logic [SPEED_W-1:0]        speed_mag;

    assign echo     = s_tdata[ECHO_W-1:0];
    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign mem_we   = (state_reg == ST_WRITE);

    // raw speed from the new distance and the last filtered one
    assign diff       = $signed({1'b0, raw_range_reg}) - $signed({1'b0, last_filt_reg});
    assign speed_prod = diff * $signed({1'b0, sample_rate_reg});

    // entries never written since reset read as zero
    assign rd_range = rd_hit_reg ? rd_data_reg[RANGE_W-1:0] : '0;
    assign rd_speed = rd_hit_reg ? $signed(rd_data_reg[MEM_W-1:RANGE_W]) : '0;
    assign rprod    = rd_range * wgt_pipe_reg;
    assign sprod    = rd_speed * $signed({1'b0, wgt_pipe_reg});

    // round to nearest on magnitudes, sign put back after the divide
    assign s_mag      = acc_s_reg[SSUM_W-1] ? SSUM_W'(-acc_s_reg) : SSUM_W'(acc_s_reg);
    assign rdiv_numer = acc_r_reg + RSUM_W'(DEN / 2);
    assign sdiv_numer = s_mag + SSUM_W'(DEN / 2);
    assign div_start  = (state_reg == ST_ROUND);
    assign speed_mag  = sdiv_quot[SPEED_W-1:0];

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_sound_reg  <= erswma_pkg::HALF_SOUND_RST;
            sample_rate_reg <= erswma_pkg::SAMPLE_RATE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                erswma_pkg::REG_HALF_SOUND:  half_sound_reg  <= cfg_data[HALF_W-1:0];
                erswma_pkg::REG_SAMPLE_RATE: sample_rate_reg <= cfg_data[SPS_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        slot_next   = slot_reg;
        rd_idx_next = rd_idx_reg;
        wgt_next    = wgt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_SPEED;
                end
            end
            ST_SPEED:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                // walk starts at the newest entry, which this cycle writes
                rd_idx_next = slot_reg;
                wgt_next    = TOP_WGT;
                state_next  = ST_WALK;
            end
            ST_WALK:
            begin
                rd_idx_next = (rd_idx_reg == '0) ? LAST_SLOT : rd_idx_reg - 1'b1;
                wgt_next    = wgt_reg - 1'b1;
                if (wgt_reg == WGT_W'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!rdiv_busy && !sdiv_busy)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    slot_next  = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            rd_idx_reg    <= '0;
            wgt_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            valid_reg     <= '0;
            last_filt_reg <= '0;
            rd_hit_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            slot_reg   <= slot_next;
            rd_idx_reg <= rd_idx_next;
            wgt_reg    <= wgt_next;
            rd_vld_reg <= (state_reg == ST_WALK);
            rd_hit_reg <= valid_reg[rd_idx_reg];
            if (mem_we)
            begin
                valid_reg[slot_reg] <= 1'b1;
            end
            if (state_reg == ST_OUT && out_free)
            begin
                m_tvalid_reg  <= 1'b1;
                last_filt_reg <= rdiv_quot[RANGE_W-1:0];
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // ring memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[slot_reg] <= {raw_speed_reg, raw_range_reg};
        end
        rd_data_reg <= ring_mem[rd_idx_reg];
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        wgt_pipe_reg <= wgt_reg;
        if (in_fire)
        begin
            raw_range_reg <= echo * half_sound_reg;
        end
        if (state_reg == ST_SPEED)
        begin
            raw_speed_reg <= speed_prod[SPEED_W-1:0];
        end
        if (state_reg == ST_WRITE)
        begin
            acc_r_reg <= '0;
            acc_s_reg <= '0;
        end
        else if (rd_vld_reg)
        begin
            acc_r_reg <= acc_r_reg + RSUM_W'(rprod);
            acc_s_reg <= acc_s_reg + SSUM_W'(sprod);
        end
        if (div_start)
        begin
            neg_reg <= acc_s_reg[SSUM_W-1];
        end
        if (state_reg == ST_OUT && out_free)
        begin
            out_range_reg <= rdiv_quot[RANGE_W-1:0];
            out_speed_reg <= neg_reg ? (~speed_mag + 1'b1) : speed_mag;
        end
    end

    erswma_serial_div #(
        .NUM_W   (RSUM_W),
        .DIVISOR (DEN)
    ) u_range_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (rdiv_numer),
        .busy  (rdiv_busy),
        .quot  (rdiv_quot)
    );

    erswma_serial_div #(
        .NUM_W   (SSUM_W),
        .DIVISOR (DEN)
    ) u_speed_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (sdiv_numer),
        .busy  (sdiv_busy),
        .quot  (sdiv_quot)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_speed_reg, out_range_reg};

`ifndef SYNTHESIS
    // an accepted item always starts the speed step next
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == ST_SPEED)
        else $error("accepted item did not enter the speed step");

    // dividers run only while the sequencer waits for them
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_DIV |-> !rdiv_busy && !sdiv_busy)
        else $error("divider busy outside the divide state");

    // a delivered result leaves the block idle with the result shown
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT && out_free |=> m_tvalid_reg && state_reg == ST_IDLE)
        else $error("result load did not complete");

    // the write slot stays inside the ring
    assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= LAST_SLOT)
        else $error("ring write slot out of range");
`endif

endmodule
